// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/bcc_pkg.sv =====
package bcc_pkg;

  typedef struct packed {
    logic        op;
    logic        first_block;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic expand_start;
    logic expand_step;
    logic load;
    logic round_step;
    logic finish;
  } cmd_t;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IV_HI = 3'd4;
  localparam logic [2:0] REG_IV_LO = 3'd5;

  localparam logic [31:0] SEED_ADD [4] = '{32'hd6, 32'h27, 32'hdd, 32'h8c};
  localparam int unsigned ROT_T [4] = '{15, 10, 15, 12};
  localparam int unsigned ROT_S [4] = '{14, 9, 21, 11};

  function automatic logic [31:0] rol(input logic [31:0] a, input int unsigned n);
    logic [63:0] d;
    d = {a, a} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w, input logic inv);
    logic [31:0] o;
    logic [7:0]  b;
    logic [15:0] p;
    for (int k = 0; k < 4; k++) begin
      b = w[8*k +: 8];
      if (inv) p = 16'(8'(b - 8'd86)) * 16'd53;
      else p = 16'(b) * 16'd29 + 16'd86;
      o[8*k +: 8] = p[7:0];
    end
    return o;
  endfunction

endpackage

// ===== rtl/bcc_ram.sv =====
module bcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/bcc_datapath.sv =====
module bcc_datapath #(
  parameter int ROUNDS = 16
) (
  input  logic              clk,
  input  bcc_pkg::cmd_t     cmd,
  input  logic [3:0]        cnt,
  input  logic              cnt_last,
  input  bcc_pkg::in_item_t in_item,
  input  logic [255:0]      key,
  input  logic [127:0]      iv,
  input  logic              rst,
  output bcc_pkg::out_item_t out_item
);
  import bcc_pkg::*;

  localparam int RW = $clog2(ROUNDS);

  logic [31:0]  ks [4];
  logic [31:0]  kt [4];
  logic [31:0]  ks_next [4];
  logic [31:0]  kw [4];
  logic [31:0]  w [4];
  logic [31:0]  w_next [4];
  logic [31:0]  chain [4];
  logic [31:0]  blk [4];
  logic         op;
  logic [127:0] din;
  logic [127:0] rk_wdata;
  logic [127:0] rk_rdata;
  logic [RW-1:0] rk_waddr;
  logic [RW-1:0] rk_raddr;
  logic         rk_we;

  assign din = {in_item.data_high, in_item.data_low};

  bcc_ram #(.WIDTH(128), .DEPTH(1 << RW)) u_rk (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(rk_raddr), .rdata(rk_rdata)
  );

  // schedule: round i step writes key of round cnt
  always_comb begin
    logic [31:0] s [4];
    for (int i = 0; i < 4; i++) s[i] = ks[i];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s[(i + j) % 4] = s[(i + j) % 4] ^
          (rol(kt[(i + j) % 4], ROT_T[j]) + rol(s[(i + j) % 4], ROT_S[j]));
      end
      kw[i] = s[i];
    end
    for (int i = 0; i < 4; i++) ks_next[i] = s[i];
  end

  always_comb begin
    rk_we = 1'b0;
    rk_waddr = RW'(cnt);
    rk_wdata = {kw[0], kw[1], kw[2], kw[3]};
    if (cmd.expand_start) begin
      rk_we = 1'b1;
      rk_waddr = '0;
      rk_wdata = key[255:128];
    end else if (cmd.expand_step) begin
      rk_we = 1'b1;
      if (cnt_last) rk_wdata = key[127:0];
    end
  end

  // read address: round key used next cycle
  always_comb begin
    logic [3:0] r;
    r = cmd.load ? 4'd0 : cnt + 4'd1;
    if (cmd.load ? in_item.op : op) rk_raddr = RW'(4'(ROUNDS - 1) - r);
    else rk_raddr = RW'(r);
  end

  always_comb begin
    logic [31:0] s [4];
    logic [31:0] t;
    logic [31:0] k [4];
    for (int i = 0; i < 4; i++) k[i] = rk_rdata[127 - 32*i -: 32];
    for (int i = 0; i < 4; i++) s[i] = w[i];
    if (!op) begin
      for (int i = 0; i < 4; i++) s[i] = sbox_word(s[i], 1'b0);
      s[1] = rol(s[1], 8); s[2] = rol(s[2], 16); s[3] = rol(s[3], 24);
      t = s[3]; s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t;
      s[2] += s[3]; s[3] += s[2]; s[0] += s[1]; s[1] += s[0];
      s[0] += s[2]; s[1] += s[3]; s[2] += s[1]; s[3] += s[0];
      for (int i = 0; i < 4; i++) s[i] ^= k[i];
    end else begin
      for (int i = 0; i < 4; i++) s[i] ^= k[i];
      s[3] -= s[0]; s[2] -= s[1]; s[1] -= s[3]; s[0] -= s[2];
      s[1] -= s[0]; s[0] -= s[1]; s[3] -= s[2]; s[2] -= s[3];
      t = s[0]; s[0] = s[1]; s[1] = s[2]; s[2] = s[3]; s[3] = t;
      s[1] = rol(s[1], 24); s[2] = rol(s[2], 16); s[3] = rol(s[3], 8);
      for (int i = 0; i < 4; i++) s[i] = sbox_word(s[i], 1'b1);
    end
    for (int i = 0; i < 4; i++) w_next[i] = s[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) chain[i] <= '0;
    end else if (cmd.load) begin
      op <= in_item.op;
      blk[0] <= in_item.data_high[63:32];
      blk[1] <= in_item.data_high[31:0];
      blk[2] <= in_item.data_low[63:32];
      blk[3] <= in_item.data_low[31:0];
      for (int i = 0; i < 4; i++) begin
        logic [31:0] c;
        logic [31:0] d;
        c = in_item.first_block ? iv[127 - 32*i -: 32] : chain[i];
        d = din[127 - 32*i -: 32];
        chain[i] <= c;
        w[i] <= in_item.op ? d : d ^ c;
      end
    end else if (cmd.round_step) begin
      for (int i = 0; i < 4; i++) w[i] <= w_next[i];
    end else if (cmd.finish) begin
      for (int i = 0; i < 4; i++) begin
        if (op) begin
          w[i] <= w[i] ^ chain[i];
          chain[i] <= blk[i];
        end else begin
          chain[i] <= w[i];
        end
      end
    end
    if (cmd.expand_start) begin
      for (int i = 0; i < 4; i++) begin
        ks[i] <= key[255 - 32*i -: 32] + SEED_ADD[i];
        kt[i] <= key[127 - 32*i -: 32];
      end
    end else if (cmd.expand_step) begin
      for (int i = 0; i < 4; i++) ks[i] <= ks_next[i];
    end
  end

  assign out_item.result_high = {w[0], w[1]};
  assign out_item.result_low  = {w[2], w[3]};
endmodule

// ===== rtl/bcc_ctrl.sv =====
module bcc_ctrl #(
  parameter int ROUNDS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_stall,
  input  logic          key_write,
  output logic          in_stall,
  output logic          out_valid,
  output bcc_pkg::cmd_t cmd,
  output logic [3:0]    cnt,
  output logic          cnt_last
);
  import bcc_pkg::*;

  state_t     state, state_next;
  logic       keys_ready;
  logic [3:0] cnt_next;

  assign cnt_last = cnt == 4'(ROUNDS - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = keys_ready ? ST_LOAD : ST_EXPAND;
      ST_EXPAND: if (cnt_last) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROUND;
      ST_ROUND:  if (cnt_last) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    cnt_next = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = 4'd1;
        if (in_valid && !keys_ready) cmd.expand_start = 1'b1;
      end
      ST_EXPAND: begin
        cmd.expand_step = 1'b1;
        cnt_next = cnt + 4'd1;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        in_stall = 1'b0;
        cnt_next = '0;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        cnt_next = cnt + 4'd1;
      end
      ST_FINISH: cmd.finish = 1'b1;
      ST_OUT:    out_valid = 1'b1;
      default:   cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      keys_ready <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (key_write) keys_ready <= 1'b0;
      else if (state == ST_EXPAND && cnt_last) keys_ready <= 1'b1;
    end
  end
endmodule

// ===== rtl/block_cipher_cbc_128_top.sv =====
// 128-bit block cipher, cbc mode, 256-bit key
// configuration: apb-style port, 64-bit data, registers at 8*index
//   key words 0..3 at 0x00..0x18, iv high/low at 0x20/0x28
// input channel in_valid/in_stall carries op, first_block and the block
// output channel out_valid/out_stall carries the result block
// one block at a time: input accepted in the load cycle, then ROUNDS round
// steps of the round unit, a finish step, then the result is offered
// after any key write the next block first runs ROUNDS - 1 steps of key
// expansion, one schedule step a cycle into the round key memory
// reset clears chain to zero and marks keys as not expanded
// a stalled result holds and no new block is taken until its transfer
module block_cipher_cbc_128_top #(
  parameter int ROUNDS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bcc_pkg::out_item_t  out_item
);
  import bcc_pkg::*;

  logic [63:0] key_reg [4];
  logic [63:0] iv_hi, iv_lo;
  logic        wr;
  logic [2:0]  idx;
  cmd_t        cmd;
  logic [3:0]  cnt;
  logic        cnt_last;

  assign pready = 1'b1;
  assign idx = paddr[5:3];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
      iv_hi <= '0;
      iv_lo <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_KEY0:  key_reg[0] <= pwdata;
        REG_KEY1:  key_reg[1] <= pwdata;
        REG_KEY2:  key_reg[2] <= pwdata;
        REG_KEY3:  key_reg[3] <= pwdata;
        REG_IV_HI: iv_hi <= pwdata;
        REG_IV_LO: iv_lo <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY0:  prdata = key_reg[0];
      REG_KEY1:  prdata = key_reg[1];
      REG_KEY2:  prdata = key_reg[2];
      REG_KEY3:  prdata = key_reg[3];
      REG_IV_HI: prdata = iv_hi;
      REG_IV_LO: prdata = iv_lo;
      default:   prdata = '0;
    endcase
  end

  bcc_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .out_stall(out_stall),
    .key_write(wr && idx <= REG_KEY3), .in_stall(in_stall),
    .out_valid(out_valid), .cmd(cmd), .cnt(cnt), .cnt_last(cnt_last)
  );

  bcc_datapath #(.ROUNDS(ROUNDS)) u_dp (
    .clk(clk), .cmd(cmd), .cnt(cnt), .cnt_last(cnt_last), .in_item(in_item),
    .key({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
    .iv({iv_hi, iv_lo}), .rst(rst), .out_item(out_item)
  );
endmodule

// ===== rtl/bcc_checker.sv =====
`include "assert_macros.svh"
module bcc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic pready
);
  `ASSERT_IMPL(a_pready, clk, rst, 1'b1, pready, "pready low")
  `ASSERT_IMPL(a_excl, clk, rst, out_valid, in_stall, "input taken while result pending")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `ASSERT_NEXT(a_no_fast, clk, rst, in_valid && !in_stall, !out_valid, "result too early")
endmodule

bind block_cipher_cbc_128_top bcc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .pready(pready)
);

// ===== tb/sv/block_cipher_cbc_128_top_test.sv =====
module block_cipher_cbc_128_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bcc_pkg::*;

  localparam int NUM_ROUNDS = 16;
  localparam int LIMIT_CYCLES = 400000;

  class cbc_scoreboard;
    logic [63:0] key_w [4];
    logic [63:0] iv_hi, iv_lo;
    logic [31:0] rk [64];
    bit keys_ok;
    logic [31:0] chain [4];
    logic [31:0] work [4];
    out_item_t expected_q [$];
    int mismatches;
    int checked;

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      iv_hi = '0;
      iv_lo = '0;
      keys_ok = 0;
      foreach (chain[i]) chain[i] = '0;
      foreach (work[i]) work[i] = '0;
      foreach (rk[i]) rk[i] = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function logic [31:0] rotl(logic [31:0] a, int n);
      n = n & 31;
      if (n == 0) return a;
      return (a << n) | (a >> (32 - n));
    endfunction

    function logic [31:0] subst(logic [31:0] w, bit inv);
      logic [31:0] o;
      logic [7:0] b;
      for (int k = 0; k < 4; k++) begin
        b = w[8*k +: 8];
        if (inv) b = 8'((b - 8'd86) * 8'd53);
        else b = 8'(b * 8'd29 + 8'd86);
        o[8*k +: 8] = b;
      end
      return o;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
          key_w[idx] = v;
          keys_ok = 0;
        end
        REG_IV_HI: iv_hi = v;
        REG_IV_LO: iv_lo = v;
        default: ;
      endcase
    endfunction

    function void schedule_keys();
      logic [31:0] s [4];
      logic [31:0] t [4];
      int last, x;
      int rot_t [4];
      int rot_s [4];
      rot_t = '{15, 10, 15, 12};
      rot_s = '{14, 9, 21, 11};
      last = (NUM_ROUNDS - 1) & 15;
      for (int i = 0; i < 2; i++) begin
        rk[2*i] = key_w[i][63:32];
        rk[2*i+1] = key_w[i][31:0];
        rk[last*4 + 2*i] = key_w[2+i][63:32];
        rk[last*4 + 2*i+1] = key_w[2+i][31:0];
      end
      s[0] = rk[0] + 32'hd6;
      s[1] = rk[1] + 32'h27;
      s[2] = rk[2] + 32'hdd;
      s[3] = rk[3] + 32'h8c;
      for (int i = 0; i < 4; i++) t[i] = rk[last*4 + i];
      for (int r = 1; r + 1 < NUM_ROUNDS && r < 15; r++) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            x = (i + j) & 3;
            s[x] ^= rotl(t[x], rot_t[j]) + rotl(s[x], rot_s[j]);
          end
          rk[(r*4 + i) & 63] = s[i];
        end
      end
      for (int i = 0; i < 4; i++) work[i] = s[i];
      keys_ok = 1;
    endfunction

    function void note_input(in_item_t it);
      logic [31:0] blk [4];
      logic [31:0] tmp;
      int r;
      out_item_t e;
      if (!keys_ok) schedule_keys();
      if (it.first_block) begin
        chain = '{iv_hi[63:32], iv_hi[31:0], iv_lo[63:32], iv_lo[31:0]};
      end
      blk = '{it.data_high[63:32], it.data_high[31:0], it.data_low[63:32], it.data_low[31:0]};
      if (!it.op) begin
        for (int i = 0; i < 4; i++) work[i] = blk[i] ^ chain[i];
        for (r = 0; r < NUM_ROUNDS && r < 16; r++) begin
          for (int i = 0; i < 4; i++) work[i] = subst(work[i], 0);
          work[1] = rotl(work[1], 8);
          work[2] = rotl(work[2], 16);
          work[3] = rotl(work[3], 24);
          tmp = work[3]; work[3] = work[2]; work[2] = work[1]; work[1] = work[0];
          work[0] = tmp;
          work[2] += work[3]; work[3] += work[2]; work[0] += work[1]; work[1] += work[0];
          work[0] += work[2]; work[1] += work[3]; work[2] += work[1]; work[3] += work[0];
          for (int i = 0; i < 4; i++) work[i] ^= rk[(r*4 + i) & 63];
        end
        for (int i = 0; i < 4; i++) chain[i] = work[i];
      end else begin
        for (int i = 0; i < 4; i++) work[i] = blk[i];
        for (int n = 0; n < NUM_ROUNDS && n < 16; n++) begin
          r = NUM_ROUNDS - 1 - n;
          for (int i = 0; i < 4; i++) work[i] ^= rk[(r*4 + i) & 63];
          work[3] -= work[0]; work[2] -= work[1]; work[1] -= work[3]; work[0] -= work[2];
          work[1] -= work[0]; work[0] -= work[1]; work[3] -= work[2]; work[2] -= work[3];
          tmp = work[0]; work[0] = work[1]; work[1] = work[2]; work[2] = work[3];
          work[3] = tmp;
          work[1] = rotl(work[1], 24);
          work[2] = rotl(work[2], 16);
          work[3] = rotl(work[3], 8);
          for (int i = 0; i < 4; i++) work[i] = subst(work[i], 1);
        end
        for (int i = 0; i < 4; i++) begin
          work[i] ^= chain[i];
          chain[i] = blk[i];
        end
      end
      e.result_high = {work[0], work[1]};
      e.result_low = {work[2], work[3]};
      expected_q.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.result_high !== e.result_high || got.result_low !== e.result_low) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h_%h got %h_%h", e.result_high, e.result_low,
                   got.result_high, got.result_low);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_item;

  cbc_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;
  int sent = 0;

  always #1 clk = ~clk;

  block_cipher_cbc_128_top #(.ROUNDS(NUM_ROUNDS)) uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_block(logic op, logic first, logic [63:0] hi, logic [63:0] lo);
    in_item_t it;
    it.op = op;
    it.first_block = first;
    it.data_high = hi;
    it.data_low = lo;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    sent++;
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    while (n < 40) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic set_keys(int mode);
    for (int i = 0; i < 6; i++) begin
      case (mode)
        0: write_reg(3'(i), '0);
        1: write_reg(3'(i), '1);
        default: write_reg(3'(i), rand64());
      endcase
    end
  endtask

  task automatic random_phase(int count);
    logic op;
    int msg_len;
    while (count > 0) begin
      msg_len = $urandom_range(1, 12);
      op = 1'($urandom_range(1));
      for (int k = 0; k < msg_len && count > 0; k++) begin
        if ($urandom_range(9) == 0) op = ~op;
        send_block(op, k == 0 ? 1'b1 : ($urandom_range(19) == 0), rand64(), rand64());
        count--;
      end
    end
  endtask

  initial begin
    logic [63:0] pt_hi, pt_lo, ct_hi, ct_lo;
    repeat (12) @(posedge clk);
    rst <= 0;
    // chain is zero before any first block, keys all zero
    send_block(0, 0, '0, '0);
    send_block(1, 0, '1, '1);
    send_block(0, 1, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
    drain();
    set_keys(1);
    send_block(0, 1, '1, '0);
    send_block(1, 1, '0, '1);
    send_block(1, 0, '1, '1);
    send_block(0, 0, '0, '0);
    drain();
    set_keys(2);
    for (int i = 0; i < 6; i++) send_block(1'(i % 2), i == 0 || i == 3, rand64(), rand64());
    drain();
    // iv change alone leaves the chain alone
    write_reg(REG_IV_HI, rand64());
    write_reg(REG_IV_LO, rand64());
    send_block(0, 0, rand64(), rand64());
    send_block(0, 1, rand64(), rand64());
    send_block(1, 0, rand64(), rand64());
    // a key change mid-message
    drain();
    write_reg(REG_KEY2, rand64());
    send_block(1, 0, rand64(), rand64());
    send_block(0, 0, rand64(), rand64());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 62; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 62; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      set_keys(ph == 4 ? 1 : (ph == 6 ? 0 : 2));
      random_phase(210);
      drain();
      stall_pct = 0;
    end

    $display("sent %0d blocks, checked %0d results over 8 key and idling phases",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
